>>> rtl/glw_pkg.sv
// ----------------------------------------------------------------------------
// glw_pkg
// Shared types, constants and helper functions of the greedy line wrapper.
// ----------------------------------------------------------------------------
package glw_pkg;

  // Line buffer sizing
  localparam int LINE_GLYPHS = 32;
  localparam int CNT_W       = $clog2(LINE_GLYPHS + 2);
  localparam int PTR_W       = CNT_W;
  localparam int BUF_DEPTH   = 2 ** PTR_W;

  // Field widths
  localparam int CODE_W = 21;
  localparam int ADV_W  = 16;
  localparam int IDX_W  = 16;
  localparam int X_W    = 24;
  localparam int LINE_W = 16;

  // Configuration register indexes
  localparam logic [1:0] REG_WRAP  = 2'd0;
  localparam logic [1:0] REG_FIRST = 2'd1;
  localparam logic [1:0] REG_LINE  = 2'd2;

  // Special character codes
  localparam logic [CODE_W-1:0] CH_NUL   = 21'd0;
  localparam logic [CODE_W-1:0] CH_TAB   = 21'd9;
  localparam logic [CODE_W-1:0] CH_NL    = 21'd10;
  localparam logic [CODE_W-1:0] CH_SPACE = 21'd32;

  typedef enum logic [2:0] {
    CL_DEFAULT = 3'd0,
    CL_WS      = 3'd1,
    CL_GRAPH   = 3'd2,
    CL_QUOTE   = 3'd3,
    CL_PUNCT   = 3'd4,
    CL_OPEN    = 3'd5,
    CL_CLOSE   = 3'd6,
    CL_EOT     = 3'd7
  } cls_t;

  // Per-glyph record kept in the line buffer
  typedef struct packed {
    cls_t             cls;
    logic             nl;
    logic [ADV_W-1:0] adv;
    logic [IDX_W-1:0] idx;
  } glw_meta_t;

  // Item passed from the front to the back
  typedef struct packed {
    glw_meta_t meta;
    logic      eop;
  } glw_item_t;

  // One laid out glyph
  typedef struct packed {
    logic              ends;
    logic [LINE_W-1:0] line;
    logic [X_W-1:0]    x;
    logic [IDX_W-1:0]  idx;
  } glw_res_t;

  // Buffer occupancy seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] placed;
    logic [CNT_W-1:0] total;
  } glw_status_t;

  function automatic cls_t glw_classify(input logic [CODE_W-1:0] code);
    logic [7:0] ch;
    logic       lo;
    cls_t       c;
    ch = code[7:0];
    lo = (code[CODE_W-1:8] == '0);
    c  = CL_DEFAULT;
    if (code == CH_NUL) begin
      c = CL_EOT;
    end else if (code == CH_SPACE || code == CH_TAB || code == CH_NL) begin
      c = CL_WS;
    end else if (lo && (ch inside {"=", "+", "@", "#", "$", "%", "^", "&", "*",
                                   "\\", "|", "<", ">", "/", "~"})) begin
      c = CL_GRAPH;
    end else if (lo && (ch inside {"'", "\""})) begin
      c = CL_QUOTE;
    end else if (lo && (ch inside {",", ".", "?", "!", ";", ":", "-"})) begin
      c = CL_PUNCT;
    end else if (lo && (ch inside {"(", "[", "{"})) begin
      c = CL_OPEN;
    end else if (lo && (ch inside {")", "]", "}"})) begin
      c = CL_CLOSE;
    end
    return c;
  endfunction

  // Break opportunity between a glyph and its right neighbor
  function automatic logic glw_break_after(input cls_t cc, input logic cnl,
                                           input cls_t nc, input logic nnl);
    logic b;
    if (cc == CL_EOT || cnl) begin
      b = 1'b1;
    end else if (cc == CL_DEFAULT && nc == CL_PUNCT) begin
      b = 1'b0;
    end else if ((cc == CL_WS) != (nc == CL_WS)) begin
      b = 1'b1;
    end else if (cc == CL_WS && nnl) begin
      b = 1'b1;
    end else if (cc == CL_PUNCT && nc != CL_PUNCT && nc != CL_CLOSE && nc != CL_QUOTE) begin
      b = 1'b1;
    end else begin
      b = 1'b0;
    end
    return b;
  endfunction

  // Saturating x add
  function automatic logic [X_W-1:0] glw_sat_add(input logic [X_W-1:0] a,
                                                 input logic [X_W-1:0] b);
    logic [X_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[X_W] ? {X_W{1'b1}} : s[X_W-1:0];
  endfunction

endpackage

>>> rtl/glw_front.sv
// ----------------------------------------------------------------------------
// glw_front
// Accepts glyphs, numbers them within the paragraph and classifies them.
// ----------------------------------------------------------------------------
module glw_front
  import glw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic [39:0] in_tdata,   // char_code[20:0], advance[36:21], zero pad
  input  logic      in_tlast,     // end_of_paragraph
  output logic      push_valid,
  input  logic      push_ready,
  output glw_item_t push_item
);

  logic [IDX_W-1:0] next_idx_r, next_idx_nxt;
  logic [CODE_W-1:0] code;

  assign code       = in_tdata[CODE_W-1:0];
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  // Classify and tag the glyph
  always_comb begin
    push_item.meta.cls = glw_classify(code);
    push_item.meta.nl  = (code == CH_NL);
    push_item.meta.adv = in_tdata[CODE_W +: ADV_W];
    push_item.meta.idx = next_idx_r;
    push_item.eop      = in_tlast;
  end

  // Advance the paragraph index, saturating; restart after the last glyph
  always_comb begin
    next_idx_nxt = next_idx_r;
    if (in_tvalid && push_ready) begin
      if (in_tlast) begin
        next_idx_nxt = '0;
      end else if (next_idx_r != {IDX_W{1'b1}}) begin
        next_idx_nxt = next_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_idx_r <= '0;
    end else begin
      next_idx_r <= next_idx_nxt;
    end
  end

endmodule

>>> rtl/glw_fifo.sv
// ----------------------------------------------------------------------------
// glw_fifo
// Two-entry queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module glw_fifo
  import glw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  glw_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output glw_item_t rd_item
);

  glw_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Move pointers and count
  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the payload
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> rtl/glw_back.sv
// ----------------------------------------------------------------------------
// glw_back
// Line engine: places glyphs, backtracks to break points and emits lines.
// ----------------------------------------------------------------------------
module glw_back
  import glw_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [X_W-1:0]  cfg_wdata,
  input  logic            item_valid,
  output logic            item_ready,
  input  glw_item_t       item,
  output logic            out_valid,
  input  logic            out_ready,
  output glw_res_t        out_res,
  output logic            out_last,
  output glw_status_t     status
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_READ    = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_SCAN_RD = 8'b0000_1000,
    S_SCAN_EV = 8'b0001_0000,
    S_EMIT_RD = 8'b0010_0000,
    S_EMIT_WR = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  typedef enum logic [1:0] {
    AFT_FULL = 2'd0,
    AFT_NL   = 2'd1,
    AFT_WRAP = 2'd2,
    AFT_EOP  = 2'd3
  } aft_t;

  // Line buffer: pending and placed glyphs between head and head + total
  glw_meta_t      meta_mem [BUF_DEPTH];
  logic [X_W-1:0] x_mem    [BUF_DEPTH];
  glw_meta_t      meta_a_q, meta_b_q;
  logic [X_W-1:0] x_q;

  state_t            state_r, state_nxt;
  aft_t              after_r, after_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  placed_r, placed_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  scan_e_r, scan_e_nxt;
  logic [CNT_W-1:0]  emit_k_r, emit_k_nxt;
  logic [CNT_W-1:0]  emit_n_r, emit_n_nxt;
  logic [X_W-1:0]    pen_r, pen_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [ADV_W-1:0]  nl_adv_r, nl_adv_nxt;
  logic              fresh_r, fresh_nxt;
  logic              nocheck_r, nocheck_nxt;
  logic              eop_r, eop_nxt;
  logic              stage_v_r, stage_v_nxt;
  logic              out_v_r, out_v_nxt;
  glw_res_t          stage_r, stage_new, out_res_r;
  logic              out_last_r;
  logic [X_W-1:0]    wrap_r, first_r, lstart_r;

  logic [PTR_W-1:0] p_addr, tail_addr, scan_addr, scan_nx_addr, emit_addr, rd_a_addr;
  logic             meta_we, x_we, stage_load, out_load, out_load_last, out_free;
  logic             do_place, over;
  logic [X_W-1:0]   step, adv_x;
  logic [X_W:0]     reach;

  assign p_addr       = head_r + placed_r;
  assign tail_addr    = head_r + total_r;
  assign scan_addr    = head_r + scan_e_r;
  assign scan_nx_addr = scan_addr + 1'b1;
  assign emit_addr    = head_r + emit_k_r;
  assign out_free     = !out_v_r || out_ready;
  assign adv_x        = {{(X_W-ADV_W){1'b0}}, meta_a_q.adv};
  assign reach        = {1'b0, pen_r} + {1'b0, adv_x};
  assign over         = (wrap_r != '0) && (reach > {1'b0, wrap_r});

  assign item_ready = (state_r == S_IDLE);
  assign out_valid  = out_v_r;
  assign out_res    = out_res_r;
  assign out_last   = out_last_r;
  assign status     = '{placed: placed_r, total: total_r};

  // Hold the read address while a stage waits on its data
  always_comb begin
    case (state_r)
      S_SCAN_RD, S_SCAN_EV: rd_a_addr = scan_addr;
      S_EMIT_RD, S_EMIT_WR: rd_a_addr = emit_addr;
      default:              rd_a_addr = p_addr;
    endcase
  end

  // Result taken from the glyph at the emit position
  always_comb begin
    stage_new.idx  = meta_a_q.idx;
    stage_new.x    = x_q;
    stage_new.line = line_r;
    stage_new.ends = (emit_k_r == emit_n_r - 1'b1);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    head_nxt      = head_r;
    placed_nxt    = placed_r;
    total_nxt     = total_r;
    scan_e_nxt    = scan_e_r;
    emit_k_nxt    = emit_k_r;
    emit_n_nxt    = emit_n_r;
    pen_nxt       = pen_r;
    line_nxt      = line_r;
    nl_adv_nxt    = nl_adv_r;
    fresh_nxt     = fresh_r;
    nocheck_nxt   = nocheck_r;
    eop_nxt       = eop_r;
    stage_v_nxt   = stage_v_r;
    meta_we       = 1'b0;
    x_we          = 1'b0;
    stage_load    = 1'b0;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    do_place      = 1'b0;
    step          = '0;

    // A first-line start written before any glyph also moves the pen
    if (cfg_we && cfg_addr == REG_FIRST && fresh_r) begin
      pen_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          meta_we   = 1'b1;
          total_nxt = total_r + 1'b1;
          eop_nxt   = item.eop;
          fresh_nxt = 1'b0;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        if (placed_r == total_r) begin
          if (eop_r && placed_r != '0) begin
            emit_k_nxt = '0;
            emit_n_nxt = placed_r;
            after_nxt  = AFT_EOP;
            state_nxt  = S_EMIT_RD;
          end else if (eop_r) begin
            line_nxt  = '0;
            pen_nxt   = first_r;
            fresh_nxt = 1'b1;
            eop_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (nocheck_r) begin
          // first glyph after a wrap goes in unchecked
          nocheck_nxt = 1'b0;
          do_place    = 1'b1;
          step        = adv_x;
        end else if (placed_r == CNT_W'(LINE_GLYPHS)) begin
          emit_k_nxt = '0;
          emit_n_nxt = placed_r;
          after_nxt  = AFT_FULL;
          state_nxt  = S_EMIT_RD;
        end else if (meta_a_q.nl) begin
          x_we       = 1'b1;
          placed_nxt = placed_r + 1'b1;
          nl_adv_nxt = meta_a_q.adv;
          emit_k_nxt = '0;
          emit_n_nxt = placed_r + 1'b1;
          after_nxt  = AFT_NL;
          state_nxt  = S_EMIT_RD;
        end else if (over && meta_a_q.cls == CL_WS) begin
          do_place = 1'b1;
        end else if (over && placed_r != '0) begin
          scan_e_nxt = placed_r - 1'b1;
          state_nxt  = S_SCAN_RD;
        end else begin
          do_place = 1'b1;
          step     = adv_x;
        end
        if (do_place) begin
          x_we       = 1'b1;
          placed_nxt = placed_r + 1'b1;
          pen_nxt    = glw_sat_add(pen_r, step);
          state_nxt  = S_READ;
        end
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_EV;
      end

      S_SCAN_EV: begin
        // walk back to the latest break, or close the whole line
        if (scan_e_r == '0) begin
          emit_k_nxt = '0;
          emit_n_nxt = placed_r;
          after_nxt  = AFT_WRAP;
          state_nxt  = S_EMIT_RD;
        end else if (glw_break_after(meta_a_q.cls, meta_a_q.nl,
                                     meta_b_q.cls, meta_b_q.nl)) begin
          emit_k_nxt = '0;
          emit_n_nxt = scan_e_r + 1'b1;
          after_nxt  = AFT_WRAP;
          state_nxt  = S_EMIT_RD;
        end else begin
          scan_e_nxt = scan_e_r - 1'b1;
          state_nxt  = S_SCAN_RD;
        end
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end

      S_EMIT_WR: begin
        if (!stage_v_r || out_free) begin
          stage_load  = 1'b1;
          stage_v_nxt = 1'b1;
          out_load    = stage_v_r;
          if (emit_k_r == emit_n_r - 1'b1) begin
            head_nxt   = head_r + emit_n_r;
            total_nxt  = total_r - emit_n_r;
            placed_nxt = placed_r - emit_n_r;
            if (line_r != {LINE_W{1'b1}}) begin
              line_nxt = line_r + 1'b1;
            end
            state_nxt = S_READ;
            case (after_r)
              AFT_FULL: pen_nxt = lstart_r;
              AFT_NL:   pen_nxt = glw_sat_add(lstart_r, {{(X_W-ADV_W){1'b0}}, nl_adv_r});
              AFT_WRAP: begin
                placed_nxt  = '0;
                pen_nxt     = lstart_r;
                nocheck_nxt = 1'b1;
              end
              AFT_EOP: begin
                line_nxt  = '0;
                pen_nxt   = first_r;
                fresh_nxt = 1'b1;
                eop_nxt   = 1'b0;
                state_nxt = S_DONE;
              end
              default: state_nxt = S_READ;
            endcase
          end else begin
            emit_k_nxt = emit_k_r + 1'b1;
            state_nxt  = S_EMIT_RD;
          end
        end
      end

      S_DONE: begin
        // flush the held result as the last one of this glyph
        if (!stage_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          stage_v_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_v_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      after_r   <= AFT_FULL;
      head_r    <= '0;
      placed_r  <= '0;
      total_r   <= '0;
      scan_e_r  <= '0;
      emit_k_r  <= '0;
      emit_n_r  <= '0;
      pen_r     <= '0;
      line_r    <= '0;
      fresh_r   <= 1'b1;
      nocheck_r <= 1'b0;
      eop_r     <= 1'b0;
      stage_v_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      after_r   <= after_nxt;
      head_r    <= head_nxt;
      placed_r  <= placed_nxt;
      total_r   <= total_nxt;
      scan_e_r  <= scan_e_nxt;
      emit_k_r  <= emit_k_nxt;
      emit_n_r  <= emit_n_nxt;
      pen_r     <= pen_nxt;
      line_r    <= line_nxt;
      fresh_r   <= fresh_nxt;
      nocheck_r <= nocheck_nxt;
      eop_r     <= eop_nxt;
      stage_v_r <= stage_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r   <= '0;
      first_r  <= '0;
      lstart_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WRAP:  wrap_r   <= cfg_wdata;
        REG_FIRST: first_r  <= cfg_wdata;
        REG_LINE:  lstart_r <= cfg_wdata;
        default:   wrap_r   <= wrap_r;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    nl_adv_r <= nl_adv_nxt;
    if (stage_load) begin
      stage_r <= stage_new;
    end
    if (out_load) begin
      out_res_r  <= stage_r;
      out_last_r <= out_load_last;
    end
  end

  // Line buffer memories
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[tail_addr] <= item.meta;
    end
    if (x_we) begin
      x_mem[p_addr] <= pen_r;
    end
    meta_a_q <= meta_mem[rd_a_addr];
    meta_b_q <= meta_mem[scan_nx_addr];
    x_q      <= x_mem[rd_a_addr];
  end

endmodule

>>> rtl/greedy_line_wrapper_top.sv
// A glyph passes the queue, is taken in S_IDLE, placed via S_READ and S_DECIDE
// and finished in S_DONE; a backtrack scan step adds S_SCAN_RD and S_SCAN_EV,
// a glyph of a closing line S_EMIT_RD and S_EMIT_WR. A new glyph is taken only
// in S_IDLE, after the last; placement, scan and output share one read address.
// Reset (rst_n low, synchronous): empties buffer and queue, zeroes registers,
// counters and pen x; buffer contents are not cleared.
// ----------------------------------------------------------------------------
// greedy_line_wrapper_top
// Greedy word wrapper: buffers a line of glyphs and emits their x positions.
// ----------------------------------------------------------------------------
module greedy_line_wrapper_top
  import glw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // char_code[20:0], advance[36:21], zero pad
  input  logic        in_tlast,   // end_of_paragraph
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // glyph_index[15:0], glyph_x[39:16],
                                  // line_number[55:40], ends_line[56], zero pad
  output logic        out_tlast   // last result of this glyph
);

  logic        push_valid, push_ready, pop_valid, pop_ready;
  glw_item_t   push_item, pop_item;
  glw_res_t    res;
  glw_status_t st;

  glw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  glw_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_item (push_item),
    .rd_valid(pop_valid),
    .rd_ready(pop_ready),
    .rd_item (pop_item)
  );

  glw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item_valid(pop_valid),
    .item_ready(pop_ready),
    .item      (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast),
    .status    (st)
  );

  assign out_tdata = {7'b0, res.ends, res.line, res.x, res.idx};

`ifndef SYNTHESIS
  a_placed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.placed <= CNT_W'(LINE_GLYPHS))
    else $error("line buffer holds more placed glyphs than a line allows");

  a_placed_total: assert property (@(posedge clk) disable iff (!rst_n)
    st.placed <= st.total)
    else $error("placed glyph count exceeds buffered glyph count");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st.total <= CNT_W'(LINE_GLYPHS + 1))
    else $error("line buffer overfilled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");
`endif

endmodule

>>> tb/tb_greedy_line_wrapper_top.sv
// ----------------------------------------------------------------------------
// Greedy line wrapper testbench
// Streams glyph paragraphs through the wrapper under changing widths and
// start offsets. An in-bench layout predictor fills a queue of expected
// laid out glyphs. Each output transfer is checked against it, field by field.
// ----------------------------------------------------------------------------
module tb_greedy_line_wrapper_top;
  import glw_pkg::*;

  localparam int HOLD_MAX = LINE_GLYPHS + 1;
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_GLYPHS = 47;
  localparam logic [X_W-1:0] X_TOP = {X_W{1'b1}};

  typedef enum logic {ROW_CFG, ROW_GLYPH} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [1:0]        addr;
    logic [23:0]       val;
    logic [CODE_W-1:0] code;
    logic [ADV_W-1:0]  adv;
    logic              eop;
    logic              typed;
    logic [IDX_W-1:0]  t_idx;
    logic [X_W-1:0]    t_x;
    logic [LINE_W-1:0] t_line;
  } row_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [X_W-1:0]    x;
    logic [LINE_W-1:0] line;
    logic              ends;
    logic              last;
  } laid_glyph_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [23:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tlast;

  greedy_line_wrapper_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected glyphs and run bookkeeping
  laid_glyph_t laid_q[$];
  int err_count = 0;
  int glyphs_sent = 0;
  int results_seen = 0;
  int lines_seen = 0;
  int cfg_writes = 0;
  bit calm = 1'b0;

  // Hand-written expectation waiting for the next accepted glyph
  bit typed_due = 1'b0;
  laid_glyph_t typed_want;

  // Layout predictor state
  int unsigned wrap_w, first_x, start_x;
  int unsigned h_code[LINE_GLYPHS], h_adv[LINE_GLYPHS];
  int unsigned h_x[LINE_GLYPHS], h_idx[LINE_GLYPHS];
  int unsigned h_cnt, pen, line_no, gidx;
  bit fresh;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want,
             results_seen);
    err_count++;
  endtask

  function automatic cls_t char_class(input int unsigned c);
    cls_t r;
    case (c)
      0: r = CL_EOT;
      CH_SPACE, CH_TAB, CH_NL: r = CL_WS;
      "=", "+", "@", "#", "$", "%", "^", "&", "*", "\\", "|", "<", ">", "/", "~":
        r = CL_GRAPH;
      "'", "\"": r = CL_QUOTE;
      ",", ".", "?", "!", ";", ":", "-": r = CL_PUNCT;
      "(", "[", "{": r = CL_OPEN;
      ")", "]", "}": r = CL_CLOSE;
      default: r = CL_DEFAULT;
    endcase
    return r;
  endfunction

  function automatic bit may_break(input int unsigned c, input int unsigned n);
    cls_t cc, nc;
    cc = char_class(c);
    nc = char_class(n);
    if (cc == CL_EOT || c == CH_NL) return 1'b1;
    if (cc == CL_DEFAULT && nc == CL_PUNCT) return 1'b0;
    if ((cc == CL_WS) != (nc == CL_WS)) return 1'b1;
    if (cc == CL_WS && n == CH_NL) return 1'b1;
    if (cc == CL_PUNCT && nc != CL_PUNCT && nc != CL_CLOSE && nc != CL_QUOTE)
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned x_add(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > X_TOP) ? X_TOP : s;
  endfunction

  // Close the first n held glyphs as one line and shift the rest down
  task automatic close_line(input int unsigned n);
    laid_glyph_t g;
    if (n > h_cnt) n = h_cnt;
    if (n == 0) return;
    for (int k = 0; k < n; k++) begin
      g.idx = IDX_W'(h_idx[k]);
      g.x = X_W'(h_x[k]);
      g.line = LINE_W'(line_no);
      g.ends = (k == n - 1);
      g.last = 1'b0;
      laid_q = {laid_q, g};
    end
    for (int k = 0; k + n < h_cnt; k++) begin
      h_code[k] = h_code[k + n];
      h_adv[k] = h_adv[k + n];
      h_x[k] = h_x[k + n];
      h_idx[k] = h_idx[k + n];
    end
    h_cnt -= n;
    if (line_no < 16'hFFFF) line_no++;
  endtask

  task automatic hold_glyph(input int unsigned c, input int unsigned a,
                            input int unsigned ix, input int unsigned step);
    if (h_cnt >= LINE_GLYPHS) return;
    h_code[h_cnt] = c;
    h_adv[h_cnt] = a;
    h_x[h_cnt] = pen;
    h_idx[h_cnt] = ix;
    h_cnt++;
    pen = x_add(pen, step);
  endtask

  task automatic set_reg(input logic [1:0] addr, input int unsigned v);
    if (addr == REG_WRAP) wrap_w = v;
    else if (addr == REG_FIRST) begin
      first_x = v;
      if (fresh) pen = v;
    end else if (addr == REG_LINE) start_x = v;
  endtask

  // Predict the laid out glyphs that one accepted glyph releases
  task automatic wrap_glyph(input int unsigned code, input int unsigned adv,
                            input bit eop);
    int unsigned qc[HOLD_MAX], qa[HOLD_MAX], qi[HOLD_MAX];
    int unsigned lc[HOLD_MAX], la[HOLD_MAX], li[HOLD_MAX];
    int unsigned qh, qn, c, a, ix, e, cl, n, m, nb;
    nb = laid_q.size();
    fresh = 1'b0;
    qc[0] = code;
    qa[0] = adv;
    qi[0] = gidx;
    qh = 0;
    qn = 1;
    if (gidx < 16'hFFFF) gidx++;
    while (qh < qn) begin
      c = qc[qh];
      a = qa[qh];
      ix = qi[qh];
      qh++;
      if (h_cnt >= LINE_GLYPHS) begin
        close_line(h_cnt);
        pen = start_x;
      end
      if (c == CH_NL) begin
        hold_glyph(c, a, ix, 0);
        close_line(h_cnt);
        pen = x_add(start_x, a);
      end else if (wrap_w != 0 && pen + a > wrap_w) begin
        if (char_class(c) == CL_WS) begin
          hold_glyph(c, a, ix, 0);
        end else if (h_cnt > 0) begin
          // Backtrack to the latest break, then lay the carry out again
          e = h_cnt - 1;
          while (e > 0 && !may_break(h_code[e], (e + 1 < h_cnt) ? h_code[e + 1] : c))
            e--;
          cl = (e > 0) ? e + 1 : h_cnt;
          close_line(cl);
          m = h_cnt;
          n = 0;
          for (int k = 0; k < m && n < HOLD_MAX; k++) begin
            lc[n] = h_code[k]; la[n] = h_adv[k]; li[n] = h_idx[k]; n++;
          end
          if (n < HOLD_MAX) begin
            lc[n] = c; la[n] = a; li[n] = ix; n++;
          end
          for (int k = qh; k < qn && n < HOLD_MAX; k++) begin
            lc[n] = qc[k]; la[n] = qa[k]; li[n] = qi[k]; n++;
          end
          h_cnt = 0;
          pen = start_x;
          hold_glyph(lc[0], la[0], li[0], la[0]);
          for (int k = 1; k < n; k++) begin
            qc[k - 1] = lc[k]; qa[k - 1] = la[k]; qi[k - 1] = li[k];
          end
          qh = 0;
          qn = n - 1;
        end else begin
          hold_glyph(c, a, ix, a);
        end
      end else begin
        hold_glyph(c, a, ix, a);
      end
    end
    if (eop) begin
      close_line(h_cnt);
      line_no = 0;
      gidx = 0;
      pen = first_x;
      fresh = 1'b1;
    end
    if (laid_q.size() > nb) laid_q[$].last = 1'b1;
  endtask

  // Offer one glyph and hold it until the transfer, then idle at random
  task automatic send_glyph(input logic [CODE_W-1:0] code, input logic [ADV_W-1:0] adv,
                            input logic eop);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, adv, code};
    in_tlast <= eop;
    do @(posedge clk); while (!in_tready);
    wrap_glyph(code, adv, eop);
    // Swap in the hand-written expectation before the result can leave
    if (typed_due) begin
      laid_q[$] = typed_want;
      typed_due = 1'b0;
    end
    glyphs_sent++;
    gap = 0;
    if (!calm && $urandom_range(0, 99) < 35)
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the block, then let the last hidden work settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (laid_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [23:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_reg(addr, v);
    cfg_writes++;
  endtask

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CODE_W'("a" + $urandom_range(0, 25));
    if (r < 67) return CH_SPACE;
    if (r < 70) return CH_TAB;
    if (r < 74) return CH_NL;
    if (r < 82) return CODE_W'(",.?!;:-" >> (8 * $urandom_range(0, 6)) & 8'hFF);
    if (r < 85) return CODE_W'($urandom_range(0, 1) ? "'" : "\"");
    if (r < 89) return CODE_W'("([{)]}" >> (8 * $urandom_range(0, 5)) & 8'hFF);
    if (r < 92) return CODE_W'("=+@#$%^&*\\|<>/~" >> (8 * $urandom_range(0, 14)) & 8'hFF);
    if (r < 94) return CH_NUL;
    return CODE_W'($urandom_range(0, 21'h10FFFF));
  endfunction

  function automatic logic [ADV_W-1:0] pick_adv();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ADV_W'($urandom_range(16, 200));
    if (r < 95) return ADV_W'($urandom_range(0, 15));
    return ADV_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [23:0] pick_reg(input bit is_wrap);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'd0;
    if (r == 1) return X_TOP;
    if (is_wrap) return (r < 4) ? X_W'($urandom_range(1, 40)) : X_W'($urandom_range(100, 1500));
    return X_W'($urandom_range(0, 200));
  endfunction

  // Directed rows: register settings, field extremes and special glyphs
  row_t dir_rows [27] = '{
    '{ROW_CFG,   REG_WRAP,  24'd0,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_FIRST, 24'd0,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_LINE,  24'd0,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("A"), 16'd16, 1'b1, 1'b1, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   21'h10FFFF, 16'hFFFF, 1'b1, 1'b1, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   21'h1FFFFF, 16'h0000, 1'b1, 1'b1, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_FIRST, X_TOP,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("B"), 16'hFFFF, 1'b1, 1'b1, 16'd0, X_TOP, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("C"), 16'd1, 1'b1, 1'b1, 16'd0, X_TOP, 16'd0},
    '{ROW_CFG,   REG_FIRST, 24'd16,  21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_LINE,  24'd8,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_WRAP,  24'd100, 21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("a"), 16'd40, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("b"), 16'd40, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CH_SPACE, 16'd40, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("c"), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("d"), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CH_NL, 16'd5, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CH_TAB, 16'd20, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("x"), 16'd90, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("-"), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("("), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'(")"), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("\""), 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CH_NUL, 16'd30, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_GLYPH, REG_WRAP,  24'd0,   CODE_W'("="), 16'd200, 1'b1, 1'b0, 16'd0, 24'd0, 16'd0},
    '{ROW_CFG,   REG_WRAP,  X_TOP,   21'd0,  16'd0, 1'b0, 1'b0, 16'd0, 24'd0, 16'd0}
  };

  // Stimulus
  initial begin
    int plen;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_WRAP;
    cfg_wdata = 24'd0;
    in_tvalid = 1'b0;
    in_tdata = 40'd0;
    in_tlast = 1'b0;
    wrap_w = 0; first_x = 0; start_x = 0;
    h_cnt = 0; pen = 0; line_no = 0; gidx = 0; fresh = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].addr, dir_rows[i].val);
      end else begin
        // Lone-glyph rows carry their expected result in the table
        if (dir_rows[i].typed) begin
          typed_want = '{dir_rows[i].t_idx, dir_rows[i].t_x, dir_rows[i].t_line,
                         1'b1, 1'b1};
          typed_due = 1'b1;
        end
        send_glyph(dir_rows[i].code, dir_rows[i].adv, dir_rows[i].eop);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(REG_WRAP, pick_reg(1'b1));
      write_reg(REG_FIRST, ($urandom_range(0, 7) == 0) ? X_TOP : pick_reg(1'b0));
      write_reg(REG_LINE, pick_reg(1'b0));
      calm = (p % 4 == 3);
      plen = PHASE_GLYPHS;
      for (int k = 0; k < plen; k++)
        send_glyph(pick_code(), pick_adv(), $urandom_range(0, 39) == 0);
    end
    calm = 1'b0;
    wait_idle();

    $display("covered %0d glyphs, %0d laid out results on %0d lines, %0d register writes",
             glyphs_sent, results_seen, lines_seen, cfg_writes);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Output side: check each transfer, stall at random, one long hold-off
  int stall = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    laid_glyph_t w;
    int r;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (out_tdata[56]) lines_seen++;
        if (laid_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[15:0], 0);
        end else begin
          w = laid_q.pop_front();
          if (out_tdata[15:0] != w.idx) report_mismatch("glyph_index", out_tdata[15:0], w.idx);
          if (out_tdata[39:16] != w.x) report_mismatch("glyph_x", out_tdata[39:16], w.x);
          if (out_tdata[55:40] != w.line)
            report_mismatch("line_number", out_tdata[55:40], w.line);
          if (out_tdata[56] != w.ends) report_mismatch("ends_line", out_tdata[56], w.ends);
          if (out_tlast != w.last) report_mismatch("last", out_tlast, w.last);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (!hold_done && glyphs_sent >= 120 && out_tvalid) begin
        hold_done = 1'b1;
        hold_cnt = 600;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (calm || r < 70) begin
          out_tready <= 1'b1;
        end else begin
          stall = (r < 97) ? $urandom_range(0, 2) : $urandom_range(20, 80);
          out_tready <= 1'b0;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #(12 * 20000000);
    $display("timeout with %0d results outstanding", laid_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
